// ===== hw/rtl/rta_pkg.sv =====
`timescale 1ns / 1ps

package rta_pkg;

  // operand widths of the shared engines
  localparam int unsigned CNT_W  = 40;   // class counts
  localparam int unsigned TOT_W  = 41;   // case total
  localparam int unsigned RUN_W  = 32;
  localparam int unsigned MUL_W  = 208;  // multiplicand and product
  localparam int unsigned MB_W   = 83;   // multiplier operand
  localparam int unsigned REM_W  = 240;  // division remainder
  localparam int unsigned QUO_W  = 63;   // quotient bits kept, top bit flags saturation
  localparam int unsigned ROOT_W = 31;

  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LD_PQ  = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_ST_PQ  = 4'd3;
  localparam logic [3:0] OP_ST_X   = 4'd4;
  localparam logic [3:0] OP_ABS    = 4'd5;
  localparam logic [3:0] OP_CORR   = 4'd6;
  localparam logic [3:0] OP_LD_BB  = 4'd7;
  localparam logic [3:0] OP_ST_T   = 4'd8;
  localparam logic [3:0] OP_ST_NUM = 4'd9;
  localparam logic [3:0] OP_ST_DEN = 4'd10;
  localparam logic [3:0] OP_DIV    = 4'd11;
  localparam logic [3:0] OP_SQ_INI = 4'd12;
  localparam logic [3:0] OP_SQ     = 4'd13;
  localparam logic [3:0] OP_OUT    = 4'd14;

  typedef struct packed {
    logic       acc_en;  // input transfer this cycle
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic degen;
    logic zero;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rta_datapath.sv =====
`timescale 1ns / 1ps

module rta_datapath #(
  parameter int unsigned SMALL_SAMPLE_LIMIT = 50
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [31:0]              cfg_wr_data,
  input  logic [31:0]              in_sample,
  input  logic [15:0]              in_weight,
  input  logic                     in_missing,
  input  rta_pkg::dp_cmd_t         cmd,
  output rta_pkg::dp_stat_t        stat,
  output logic [191:0]             out_data,
  output logic                     out_degen
);

  localparam int unsigned CW = rta_pkg::CNT_W;
  localparam int unsigned TW = rta_pkg::TOT_W;
  localparam int unsigned MW = rta_pkg::MUL_W;
  localparam int unsigned BW = rta_pkg::MB_W;
  localparam int unsigned RW = rta_pkg::REM_W;
  localparam int unsigned QW = rta_pkg::QUO_W;
  localparam int unsigned SW = rta_pkg::ROOT_W;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_ABOVE = 2'd1;
  localparam logic [1:0] SIGN_BELOW = 2'd2;

  logic [31:0]    cutpoint_r;
  logic [CW-1:0]  below_r, above_r;
  logic [31:0]    runs_r;
  logic [1:0]     sign_r;

  logic [79:0]    pq_r;
  logic [72:0]    x_r;
  logic [BW-1:0]  b_r;
  logic           neg_r, zero_r;
  logic [MW-1:0]  ma_r, acc_r;
  logic [BW-1:0]  mb_r;
  logic [RW-1:0]  rem_r, dsh_r;
  logic [QW-1:0]  q_r;
  logic [SW-1:0]  m_r, mask_r;

  logic [191:0]   out_data_r;
  logic           out_degen_r;

  // accumulate
  logic           is_above;
  logic [1:0]     sign_new;
  logic [CW:0]    add_sum;
  logic [CW-1:0]  add_sat;

  always_comb begin
    is_above = $signed(in_sample) >= $signed(cutpoint_r);
    sign_new = is_above ? SIGN_ABOVE : SIGN_BELOW;
    add_sum  = {1'b0, (is_above ? above_r : below_r)} + {{(CW + 1 - 16){1'b0}}, in_weight};
    add_sat  = add_sum[CW] ? {CW{1'b1}} : add_sum[CW-1:0];
  end

  // statistic terms
  logic [TW-1:0]  n;
  logic [81:0]    y, xw, a_abs;
  logic           x_lt_y;
  logic [BW-1:0]  nw, bc;
  logic           n_small;
  logic [80:0]    w;
  logic [TW-1:0]  nm1;
  logic           degen;
  logic           div_ge;
  logic [SW-1:0]  cand;
  logic [2*SW-1:0] cand_sq;
  logic [31:0]    mag, z_pos, z_neg, z_val;

  always_comb begin
    n       = {1'b0, above_r} + {1'b0, below_r};
    y       = {1'b0, pq_r, 1'b0} + {41'b0, n};
    xw      = {9'b0, x_r};
    x_lt_y  = xw < y;
    a_abs   = x_lt_y ? (y - xw) : (xw - y);
    nw      = {{(BW - TW){1'b0}}, n};
    bc      = b_r - nw;
    n_small = n < TW'(SMALL_SAMPLE_LIMIT);
    w       = {pq_r, 1'b0} - {40'b0, n};
    nm1     = n - TW'(1);
    degen   = (below_r == '0) || (above_r == '0) || (n == TW'(1));
    div_ge  = rem_r >= dsh_r;
    cand    = m_r | mask_r;
    cand_sq = cand * cand;
    mag     = q_r[QW-1] ? 32'h8000_0000 : {1'b0, m_r};
    z_pos   = q_r[QW-1] ? 32'h7FFF_FFFF : {1'b0, m_r};
    z_neg   = 32'd0 - mag;
    z_val   = (degen || zero_r) ? 32'd0 : (neg_r ? z_neg : z_pos);
  end

  // configuration and batch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutpoint_r <= '0;
      below_r    <= '0;
      above_r    <= '0;
      runs_r     <= '0;
      sign_r     <= SIGN_NONE;
    end else begin
      if (cfg_wr_en) cutpoint_r <= cfg_wr_data;
      if (cmd.acc_en && !in_missing) begin
        if (is_above) above_r <= add_sat;
        else          below_r <= add_sat;
        if (sign_new != sign_r && runs_r != 32'hFFFF_FFFF) runs_r <= runs_r + 32'd1;
        sign_r <= sign_new;
      end else if (cmd.op == rta_pkg::OP_OUT) begin
        below_r <= '0;
        above_r <= '0;
        runs_r  <= '0;
        sign_r  <= SIGN_NONE;
      end
    end
  end

  // arithmetic engines: shift-add multiplier, restoring divider, bitwise root
  always_ff @(posedge clk) begin
    case (cmd.op)
      rta_pkg::OP_LD_PQ: begin
        ma_r  <= MW'(above_r);
        mb_r  <= BW'(below_r);
        acc_r <= '0;
      end
      rta_pkg::OP_MUL: begin
        if (mb_r[0]) acc_r <= acc_r + ma_r;
        ma_r <= {ma_r[MW-2:0], 1'b0};
        mb_r <= {1'b0, mb_r[BW-1:1]};
      end
      rta_pkg::OP_ST_PQ: begin
        pq_r  <= acc_r[79:0];
        ma_r  <= MW'(runs_r);
        mb_r  <= BW'(n);
        acc_r <= '0;
      end
      rta_pkg::OP_ST_X: begin
        x_r <= acc_r[72:0];
      end
      rta_pkg::OP_ABS: begin
        neg_r <= x_lt_y;
        b_r   <= {a_abs, 1'b0};
      end
      rta_pkg::OP_CORR: begin
        if (n_small) begin
          zero_r <= (b_r < nw) || (bc == '0);
          b_r    <= bc;
        end else begin
          zero_r <= b_r == '0;
        end
      end
      rta_pkg::OP_LD_BB: begin
        ma_r  <= MW'(b_r);
        mb_r  <= b_r;
        acc_r <= '0;
      end
      rta_pkg::OP_ST_T: begin
        ma_r  <= acc_r;
        mb_r  <= BW'(nm1);
        acc_r <= '0;
      end
      rta_pkg::OP_ST_NUM: begin
        rem_r <= {1'b0, acc_r[206:0], 32'b0};
        ma_r  <= MW'(pq_r);
        mb_r  <= BW'(w);
        acc_r <= '0;
      end
      rta_pkg::OP_ST_DEN: begin
        // divisor is 8*den shifted to the top quotient bit
        dsh_r <= {14'b0, acc_r[160:0], 65'b0};
        q_r   <= '0;
      end
      rta_pkg::OP_DIV: begin
        if (div_ge) rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QW-2:0], div_ge};
        dsh_r <= {1'b0, dsh_r[RW-1:1]};
      end
      rta_pkg::OP_SQ_INI: begin
        m_r    <= '0;
        mask_r <= {1'b1, {(SW - 1){1'b0}}};
      end
      rta_pkg::OP_SQ: begin
        if (cand_sq <= q_r[QW-2:0]) m_r <= cand;
        mask_r <= {1'b0, mask_r[SW-1:1]};
      end
      rta_pkg::OP_OUT: begin
        out_data_r  <= {7'b0, z_val, runs_r, n, above_r, below_r};
        out_degen_r <= degen;
      end
      default: begin
      end
    endcase
  end

  assign stat.mul_done = mb_r == '0;
  assign stat.degen    = degen;
  assign stat.zero     = zero_r;
  assign out_data      = out_data_r;
  assign out_degen     = out_degen_r;

endmodule

// ===== hw/rtl/rta_ctrl.sv =====
`timescale 1ns / 1ps

module rta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  rta_pkg::dp_stat_t stat,
  output rta_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_MPQ   = 4'd2;
  localparam logic [3:0] S_MX    = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_CORR  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_MBB   = 4'd7;
  localparam logic [3:0] S_MNUM  = 4'd8;
  localparam logic [3:0] S_MDEN  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_SQI   = 4'd11;
  localparam logic [3:0] S_SQ    = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       out_free;

  assign out_free = !out_tvalid_r || out_tready;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.acc_en = 1'b0;
    cmd.op     = rta_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.acc_en = in_tvalid;
        if (in_tvalid && in_tlast) state_nxt = S_START;
      end
      S_START: begin
        if (stat.degen) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = rta_pkg::OP_LD_PQ;
          state_nxt = S_MPQ;
        end
      end
      S_MPQ: begin
        if (stat.mul_done) begin
          cmd.op    = rta_pkg::OP_ST_PQ;
          state_nxt = S_MX;
        end else cmd.op = rta_pkg::OP_MUL;
      end
      S_MX: begin
        if (stat.mul_done) begin
          cmd.op    = rta_pkg::OP_ST_X;
          state_nxt = S_ABS;
        end else cmd.op = rta_pkg::OP_MUL;
      end
      S_ABS: begin
        cmd.op    = rta_pkg::OP_ABS;
        state_nxt = S_CORR;
      end
      S_CORR: begin
        cmd.op    = rta_pkg::OP_CORR;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = rta_pkg::OP_LD_BB;
          state_nxt = S_MBB;
        end
      end
      S_MBB: begin
        if (stat.mul_done) begin
          cmd.op    = rta_pkg::OP_ST_T;
          state_nxt = S_MNUM;
        end else cmd.op = rta_pkg::OP_MUL;
      end
      S_MNUM: begin
        if (stat.mul_done) begin
          cmd.op    = rta_pkg::OP_ST_NUM;
          state_nxt = S_MDEN;
        end else cmd.op = rta_pkg::OP_MUL;
      end
      S_MDEN: begin
        if (stat.mul_done) begin
          cmd.op    = rta_pkg::OP_ST_DEN;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else cmd.op = rta_pkg::OP_MUL;
      end
      S_DIV: begin
        cmd.op  = rta_pkg::OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(rta_pkg::DIV_STEPS - 1)) state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op    = rta_pkg::OP_SQ_INI;
        cnt_nxt   = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op  = rta_pkg::OP_SQ;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(rta_pkg::SQRT_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.op    = rta_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (cmd.op == rta_pkg::OP_OUT) out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;

endmodule

// ===== hw/rtl/runs_test_accumulator_top.sv =====
// Input: an item without tlast is accepted whenever it is valid; a tlast item holds the input
// until its result is written, through up to five serial shift-add products
// (pq, R*n, B*B, *(n-1), pq*(2pq-n)) and a wait for a free output register.
// Throughput: one item per cycle inside a batch; the last item is set by the
// shift-add multiplier, the 63-step divider and the 31-step root loop.
// Reset (rst_n low, synchronous): counts, run tracking and cutpoint clear, no result.
`timescale 1ns / 1ps

module runs_test_accumulator_top #(
  parameter int unsigned SMALL_SAMPLE_LIMIT = 50
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // sample[31:0], weight[47:32]
  input  logic         in_tuser,   // is_missing
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // below_total, above_total, case_total, runs_total, z_scaled
  output logic         out_tuser   // degenerate
);

  rta_pkg::dp_cmd_t  cmd;
  rta_pkg::dp_stat_t stat;

  rta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  rta_datapath #(
    .SMALL_SAMPLE_LIMIT (SMALL_SAMPLE_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_sample   (in_tdata[31:0]),
    .in_weight   (in_tdata[47:32]),
    .in_missing  (in_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_tdata),
    .out_degen   (out_tuser)
  );

  // input closes after the last transfer of a batch
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still open after last transfer");

  // degenerate batch carries a zero statistic
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[184:153] == 32'd0))
    else $error("nonzero Z on degenerate result");

  // total matches the two counts
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[120:80] == ({1'b0, out_tdata[39:0]} + {1'b0, out_tdata[79:40]})))
    else $error("case total mismatch");

endmodule
